[rtl/ptc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ptc_pkg;

   localparam int unsigned FracBits = 32;
   localparam int unsigned DivSteps = 64;

   typedef enum logic [0:0] {
      CMD_TO_NS    = 1'b0,
      CMD_DEADLINE = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_REFERENCE_TSC    = 3'd0,
      CSR_SYSTEM_TIME_NS   = 3'd1,
      CSR_SCALE_MULTIPLIER = 3'd2,
      CSR_SCALE_SHIFT      = 3'd3
   } csr_index_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [63:0] tsc;
      logic [63:0] value;
      logic [31:0] rem_frac;
      logic [63:0] dq_frac;
      logic [31:0] rem_whole;
      logic [63:0] dq_whole;
   } cell_data_type;

endpackage
`default_nettype wire

[rtl/ptc_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module ptc_div_cell
   import ptc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire logic [31:0]   divisor,
   input  wire logic          valid_in,
   input  wire cell_data_type data_in,
   output logic               valid_out,
   output cell_data_type      data_out
);

   logic          valid_ff;
   cell_data_type data_ff;
   cell_data_type data_in_n;
   logic [32:0]   trial_frac;
   logic [32:0]   trial_whole;
   logic          ge_frac;
   logic          ge_whole;

   always_comb begin
      data_in_n   = data_in;
      trial_frac  = {data_in.rem_frac, data_in.dq_frac[63]};
      trial_whole = {data_in.rem_whole, data_in.dq_whole[63]};
      ge_frac     = trial_frac >= {1'b0, divisor};
      ge_whole    = trial_whole >= {1'b0, divisor};
      data_in_n.rem_frac  = ge_frac ? 32'(trial_frac - {1'b0, divisor}) : trial_frac[31:0];
      data_in_n.rem_whole = ge_whole ? 32'(trial_whole - {1'b0, divisor}) : trial_whole[31:0];
      data_in_n.dq_frac   = {data_in.dq_frac[62:0], ge_frac};
      data_in_n.dq_whole  = {data_in.dq_whole[62:0], ge_whole};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in_n;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule
`default_nettype wire

[rtl/pvclock_tsc_time_converter.sv]
`timescale 1ns / 1ps
`default_nettype none
// Pipeline from an accepted request to its response: input register, product register,
// one restoring division cell per quotient bit, output register.
// Throughput: one transaction per cycle; the whole pipeline holds while a response stalls.
// Reset: synchronous, clears all valid bits and all configuration registers to zero.
module pvclock_tsc_time_converter
   import ptc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_cmd,
   input  wire logic [63:0] req_tsc_now,
   input  wire logic [29:0] req_frac_ns,
   input  wire logic [63:0] req_whole_ns,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_value,
   output logic             rsp_divide_error,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_write_data
);

   logic [63:0]        reference_tsc_ff;
   logic [63:0]        system_time_ns_ff;
   logic [31:0]        scale_multiplier_ff;
   logic signed [5:0]  scale_shift_ff;
   logic [5:0]         shift_dist;
   logic               advance;

   logic          s1_valid_ff;
   cmd_type       s1_cmd_ff;
   logic [63:0]   s1_tsc_ff;
   logic [29:0]   s1_frac_ff;
   logic [63:0]   s1_whole_ff;
   logic [63:0]   s1_delta_ff;
   logic [63:0]   delta_in;
   logic [63:0]   delta_raw;

   logic          s2_valid_ff;
   cmd_type       s2_cmd_ff;
   logic [63:0]   s2_tsc_ff;
   logic [29:0]   s2_frac_ff;
   logic [63:0]   s2_whole_ff;
   logic [63:0]   s2_lo_ff;
   logic [63:0]   s2_hi_ff;

   logic          chain_valid [DivSteps+1];
   cell_data_type chain_data [DivSteps+1];

   logic [63:0]   count;
   logic [63:0]   count_shifted;
   logic          rsp_valid_ff;
   logic [63:0]   rsp_value_ff;
   logic [63:0]   rsp_value_in;
   logic          rsp_error_ff;
   logic          rsp_error_in;
   cell_data_type last;

   assign advance    = !(rsp_valid_ff && rsp_stall);
   assign req_stall  = !advance;
   assign shift_dist = scale_shift_ff[5] ? 6'(-scale_shift_ff) : 6'(scale_shift_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         reference_tsc_ff    <= '0;
         system_time_ns_ff   <= '0;
         scale_multiplier_ff <= '0;
         scale_shift_ff      <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_REFERENCE_TSC:    reference_tsc_ff    <= csr_write_data;
            CSR_SYSTEM_TIME_NS:   system_time_ns_ff   <= csr_write_data;
            CSR_SCALE_MULTIPLIER: scale_multiplier_ff <= csr_write_data[31:0];
            CSR_SCALE_SHIFT:      scale_shift_ff      <= signed'(csr_write_data[5:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      delta_raw = req_tsc_now - reference_tsc_ff;
      delta_in  = scale_shift_ff[5] ? (delta_raw >> shift_dist) : (delta_raw << shift_dist);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cmd_ff   <= cmd_type'(req_cmd);
         s1_tsc_ff   <= req_tsc_now;
         s1_frac_ff  <= req_frac_ns;
         s1_whole_ff <= req_whole_ns;
         s1_delta_ff <= delta_in;
         s2_cmd_ff   <= s1_cmd_ff;
         s2_tsc_ff   <= s1_tsc_ff;
         s2_frac_ff  <= s1_frac_ff;
         s2_whole_ff <= s1_whole_ff;
         s2_lo_ff    <= s1_delta_ff[31:0] * scale_multiplier_ff;
         s2_hi_ff    <= s1_delta_ff[63:32] * scale_multiplier_ff;
      end
   end

   always_comb begin
      chain_valid[0]          = s2_valid_ff;
      chain_data[0].cmd       = s2_cmd_ff;
      chain_data[0].tsc       = s2_tsc_ff;
      chain_data[0].value     = system_time_ns_ff + s2_hi_ff + {32'd0, s2_lo_ff[63:32]};
      chain_data[0].rem_frac  = '0;
      chain_data[0].dq_frac   = {2'b00, s2_frac_ff, 32'd0};
      chain_data[0].rem_whole = '0;
      chain_data[0].dq_whole  = s2_whole_ff;
   end

   for (genvar i = 0; i < DivSteps; i++) begin : g_cell
      ptc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .divisor   (scale_multiplier_ff),
         .valid_in  (chain_valid[i]),
         .data_in   (chain_data[i]),
         .valid_out (chain_valid[i+1]),
         .data_out  (chain_data[i+1])
      );
   end

   always_comb begin
      last          = chain_data[DivSteps];
      count         = last.dq_frac + {last.dq_whole[31:0], 32'd0};
      count_shifted = scale_shift_ff[5] ? (count << shift_dist) : (count >> shift_dist);
      rsp_error_in  = 1'b0;
      rsp_value_in  = last.value;
      if (last.cmd == CMD_DEADLINE) begin
         if (scale_multiplier_ff == '0) begin
            rsp_error_in = 1'b1;
            rsp_value_in = '0;
         end else begin
            rsp_value_in = last.tsc + count_shifted;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= chain_valid[DivSteps];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_value_ff <= rsp_value_in;
         rsp_error_ff <= rsp_error_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_divide_error = rsp_error_ff;

endmodule
`default_nettype wire

[verif/pvclock_tsc_time_converter_test.sv]
`timescale 1ns / 1ps
module pvclock_tsc_time_converter_test;
   import ptc_pkg::*;

   typedef struct {
      logic [63:0] value;
      logic        divide_error;
   } conversion_type;

   class conversion_scoreboard;
      logic [63:0] reference_tsc;
      logic [63:0] system_time_ns;
      logic [31:0] multiplier;
      logic [5:0]  shift;
      conversion_type pending[$];
      int errors;

      function new();
         reference_tsc = '0;
         system_time_ns = '0;
         multiplier = '0;
         shift = '0;
         errors = 0;
      endfunction

      function void write_register(logic [2:0] index, logic [63:0] data);
         case (index)
            CSR_REFERENCE_TSC: begin
               reference_tsc = data;
            end
            CSR_SYSTEM_TIME_NS: begin
               system_time_ns = data;
            end
            CSR_SCALE_MULTIPLIER: begin
               multiplier = data[31:0];
            end
            CSR_SCALE_SHIFT: begin
               shift = data[5:0];
            end
            default: begin
            end
         endcase
      endfunction

      function logic [63:0] prescale(logic [63:0] v, logic left_on_positive);
         logic [5:0] shift_amount;
         logic       go_left;
         shift_amount = shift[5] ? -shift : shift;
         go_left = shift[5] ? !left_on_positive : left_on_positive;
         return go_left ? (v << shift_amount) : (v >> shift_amount);
      endfunction

      function void note_request(logic cmd, logic [63:0] tsc, logic [29:0] frac,
                                 logic [63:0] whole);
         conversion_type r;
         logic [127:0] product;
         logic [63:0] ticks;
         r.value = '0;
         r.divide_error = 1'b0;
         if (cmd == CMD_TO_NS) begin
            product = prescale(tsc - reference_tsc, 1'b1) * {96'd0, multiplier};
            r.value = system_time_ns + product[95:32];
         end else if (multiplier == 0) begin
            r.divide_error = 1'b1;
         end else begin
            ticks = ({2'b0, frac, 32'd0} / {32'd0, multiplier})
                  + ((whole / {32'd0, multiplier}) << 32);
            r.value = tsc + prescale(ticks, 1'b0);
         end
         pending.push_back(r);
      endfunction

      task report(string msg);
         $display("error at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(logic [63:0] value, logic divide_error);
         conversion_type e;
         if (pending.size() == 0) begin
            report("unexpected response");
         end else begin
            e = pending.pop_front();
            if (value !== e.value)
               report($sformatf("value %h, expected %h", value, e.value));
            if (divide_error !== e.divide_error)
               report($sformatf("divide_error %b, expected %b", divide_error,
                                e.divide_error));
         end
      endtask
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall, req_cmd = 0;
   logic [63:0] req_tsc_now = 0, req_whole_ns = 0;
   logic [29:0] req_frac_ns = 0;
   logic rsp_valid, rsp_stall = 0, rsp_divide_error;
   logic [63:0] rsp_value;
   logic csr_write_enable = 0;
   logic [2:0] csr_index = 0;
   logic [63:0] csr_write_data = 0;

   conversion_scoreboard board = new();
   int idle_pct = 13;
   int quiet_cycles = 0;

   pvclock_tsc_time_converter dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_value, rsp_divide_error);
      if (!reset)
         rsp_stall <= ($urandom_range(99) < idle_pct);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else if (++quiet_cycles > 20000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task write_register(csr_index_type index, logic [63:0] data);
      csr_write_enable <= 1;
      csr_index <= index;
      csr_write_data <= data;
      board.write_register(index, data);
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   task send_request(logic cmd, logic [63:0] tsc, logic [29:0] frac, logic [63:0] whole);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_cmd <= cmd;
      req_tsc_now <= tsc;
      req_frac_ns <= frac;
      req_whole_ns <= whole;
      do @(posedge clock); while (req_stall);
      board.note_request(cmd, tsc, frac, whole);
   endtask

   task drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function logic [63:0] rand_small();
      return 64'($urandom_range(3) == 0 ? rand64() : $urandom >> $urandom_range(31));
   endfunction

   task apply_setting(int k);
      logic [5:0] s;
      case (k % 6)
         0: s = 6'd0;
         1: s = 6'(-32);
         2: s = 6'd31;
         3: s = 6'(-31);
         default: s = 6'($urandom_range(0, 62) - 31);
      endcase
      write_register(CSR_REFERENCE_TSC, k == 1 ? '1 : rand64());
      write_register(CSR_SYSTEM_TIME_NS, k == 2 ? '1 : rand64());
      case (k % 5)
         0: write_register(CSR_SCALE_MULTIPLIER, 64'd0);
         1: write_register(CSR_SCALE_MULTIPLIER, 64'hFFFF_FFFF);
         2: write_register(CSR_SCALE_MULTIPLIER, 64'd1);
         default: write_register(CSR_SCALE_MULTIPLIER, rand64());
      endcase
      write_register(CSR_SCALE_SHIFT, (rand64() & ~64'h3F) | 64'(s));
      csr_index <= 3'(4 + $urandom_range(3));
      csr_write_enable <= 1;
      csr_write_data <= rand64();
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   initial begin
      rsp_stall <= 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed
      send_request(CMD_DEADLINE, 64'd5, 30'd7, 64'd9);
      send_request(CMD_TO_NS, '1, '1, '1);
      drain();
      write_register(CSR_SCALE_MULTIPLIER, 64'hFFFF_FFFF);
      write_register(CSR_SCALE_SHIFT, 64'(6'(-32)));
      write_register(CSR_REFERENCE_TSC, 64'd1);
      write_register(CSR_SYSTEM_TIME_NS, '1);
      send_request(CMD_TO_NS, 64'd0, 30'd0, 64'd0);
      send_request(CMD_TO_NS, '1, 30'd0, 64'd0);
      send_request(CMD_DEADLINE, '1, '1, '1);
      send_request(CMD_DEADLINE, 64'd0, 30'd999999999, 64'd1000000000);
      send_request(CMD_DEADLINE, 64'd0, 30'd0, 64'd0);
      drain();
      write_register(CSR_SCALE_SHIFT, 64'd31);
      write_register(CSR_SCALE_MULTIPLIER, 64'd1);
      send_request(CMD_TO_NS, '1, 30'd0, 64'd0);
      send_request(CMD_DEADLINE, 64'h8000_0000_0000_0000, '1, '1);
      send_request(CMD_DEADLINE, 64'd3, 30'd1, 64'd0);
      drain();
      // random phases
      for (int k = 0; k < 14; k++) begin
         idle_pct = (k == 4) ? 0 : 13;
         apply_setting(k);
         for (int i = 0; i < 125; i++)
            send_request(1'($urandom_range(1)), rand64(), 30'($urandom),
                         $urandom_range(1) ? rand_small() : rand64());
         drain();
      end
      if (board.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
